// ===== hdl/dhcptlv_pkg.sv =====
`default_nettype none

package dhcptlv_pkg;

   // Sizes of the three option areas of a DHCP message, in bytes.
   localparam int OPTIONS_BYTES = 312;
   localparam int FILE_BYTES    = 128;
   localparam int SNAME_BYTES   = 64;

   localparam int POS_W = 9;
   localparam int LEN_W = 9;

   localparam logic [POS_W-1:0] OPTIONS_LAST = POS_W'(OPTIONS_BYTES - 1);
   localparam logic [POS_W-1:0] FILE_LAST    = POS_W'(FILE_BYTES - 1);
   localparam logic [POS_W-1:0] SNAME_LAST   = POS_W'(SNAME_BYTES - 1);

   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // Option codes with a fixed meaning.
   localparam logic [7:0] CODE_PAD      = 8'd0;
   localparam logic [7:0] CODE_END      = 8'd255;
   localparam logic [7:0] CODE_OVERLOAD = 8'd52;

   // Region tags.
   localparam logic [1:0] REGION_OPTIONS = 2'd0;
   localparam logic [1:0] REGION_FILE    = 2'd1;
   localparam logic [1:0] REGION_SNAME   = 2'd2;

   typedef enum logic [1:0] {
      PH_CODE  = 2'd0,
      PH_LEN   = 2'd1,
      PH_VALUE = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic [7:0]       bytes_left;
      logic [POS_W-1:0] position;
      logic [1:0]       active_region;
      logic [1:0]       overload_bits;
      logic             overload_seen;
      logic             collecting;
      logic             grab_overload;
      logic [LEN_W-1:0] length_sum;
      logic             match_seen;
      logic             finished;
   } scan_state_type;

   localparam scan_state_type SCAN_CLEAR = '{
      phase:         PH_CODE,
      bytes_left:    8'd0,
      position:      '0,
      active_region: REGION_OPTIONS,
      overload_bits: 2'b00,
      overload_seen: 1'b0,
      collecting:    1'b0,
      grab_overload: 1'b0,
      length_sum:    '0,
      match_seen:    1'b0,
      finished:      1'b0
   };

   typedef struct packed {
      logic             valid;
      logic [7:0]       value_byte;
      logic             value_valid;
      logic             scan_done;
      logic             found;
      logic [LEN_W-1:0] total_length;
   } scan_result_type;

   // Position of the final byte of a region.
   function automatic logic [POS_W-1:0] region_last(input logic [1:0] r);
      logic [POS_W-1:0] v;
      case (r)
         REGION_OPTIONS: v = OPTIONS_LAST;
         REGION_FILE:    v = FILE_LAST;
         default:        v = SNAME_LAST;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/dhcp_option_tlv_extract_core.sv =====
`default_nettype none

// DHCP option extractor with option-overload support.
// The req channel carries one option-area byte per item, in message order:
// the options field, then the boot-file field, then the server-name field.
// req_tuser tags each item with its region and with the start-of-message flag.
// The block walks the code-length-value options and sends one rsp item for
// every value byte of an option whose code equals the code written over the
// csr port, and one item (rsp_tlast high) on the byte that ends the scan.
// Every rsp item also carries the running found flag and collected length.
// Bytes of a region that is not being scanned, and bytes after the end of
// the scan, give no rsp item. A new message begins with message_start.
// The step logic is combinational and its result is registered, so a result
// appears in the cycle after the item is accepted. One item is accepted in
// every cycle while the result register is empty or being read.
// When the receiver stalls, the result register holds and req_tready drops.
// Reset clears the scan state and the result register and sets the wanted
// code to 1. The csr port should only be written while the block is idle.
module dhcp_option_tlv_extract_core (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [7:0]  req_tdata,    // data_byte[7:0]
   input  wire [2:0]  req_tuser,    // region[1:0], message_start[2]
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [23:0] rsp_tdata,   // value_byte[7:0], found[8], total_length[17:9], zero
   output logic [0:0] rsp_tuser,    // value_valid[0]
   output logic       rsp_tlast,    // scan_done
   input  wire        csr_wr_en,
   input  wire [7:0]  csr_wr_data
);

   dhcptlv_pkg::scan_state_type  state_ff;
   dhcptlv_pkg::scan_state_type  state_in;
   dhcptlv_pkg::scan_result_type result;
   logic [7:0]                   wanted_ff;
   logic                         space;
   logic                         accept;

   assign req_tready = space;
   assign accept     = req_tvalid && space;

   // Wanted option code, reset to 1.
   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff <= 8'd1;
      end else if (csr_wr_en) begin
         wanted_ff <= csr_wr_data;
      end
   end

   // The scan state advances only on an accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dhcptlv_pkg::SCAN_CLEAR;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   dhcptlv_step u_step (
      .state_cur     (state_ff),
      .data_byte     (req_tdata),
      .region        (req_tuser[1:0]),
      .message_start (req_tuser[2]),
      .wanted_code   (wanted_ff),
      .state_next    (state_in),
      .result        (result)
   );

   dhcptlv_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .space      (space)
   );

endmodule

`default_nettype wire

// ===== hdl/dhcptlv_step.sv =====
`default_nettype none

// Next scan state and result for one option-area byte.
module dhcptlv_step (
   input  wire dhcptlv_pkg::scan_state_type  state_cur,
   input  wire logic [7:0]                   data_byte,
   input  wire logic [1:0]                   region,
   input  wire logic                         message_start,
   input  wire logic [7:0]                   wanted_code,
   output dhcptlv_pkg::scan_state_type       state_next,
   output dhcptlv_pkg::scan_result_type      result
);

   dhcptlv_pkg::scan_state_type cur;
   logic                        last;
   logic                        emit;
   logic                        done;
   logic                        switched;
   logic [7:0]                  left_dec;

   always_comb begin
      cur        = message_start ? dhcptlv_pkg::SCAN_CLEAR : state_cur;
      state_next = cur;
      emit       = 1'b0;
      done       = 1'b0;
      switched   = 1'b0;
      last       = (cur.position >= dhcptlv_pkg::region_last(cur.active_region));
      left_dec   = (cur.bytes_left != 8'd0) ? cur.bytes_left - 8'd1 : 8'd0;

      if (!cur.finished && (region == cur.active_region)) begin
         case (cur.phase)
            dhcptlv_pkg::PH_CODE: begin
               if (last) begin
                  // No room for a length byte: the region ends here.
                  done = 1'b1;
               end else if (data_byte == dhcptlv_pkg::CODE_PAD) begin
                  done = 1'b0;
               end else if (data_byte == dhcptlv_pkg::CODE_END) begin
                  if (cur.overload_bits[0]) begin
                     state_next.overload_bits[0] = 1'b0;
                     state_next.active_region    = dhcptlv_pkg::REGION_FILE;
                     state_next.position         = '0;
                     switched                    = 1'b1;
                  end else if (cur.overload_bits[1]) begin
                     state_next.overload_bits[1] = 1'b0;
                     state_next.active_region    = dhcptlv_pkg::REGION_SNAME;
                     state_next.position         = '0;
                     switched                    = 1'b1;
                  end else begin
                     done = 1'b1;
                  end
               end else begin
                  state_next.collecting = (data_byte == wanted_code);
                  if (data_byte == wanted_code) begin
                     state_next.match_seen = 1'b1;
                  end
                  state_next.grab_overload =
                     (data_byte == dhcptlv_pkg::CODE_OVERLOAD) && !cur.overload_seen;
                  if ((data_byte == dhcptlv_pkg::CODE_OVERLOAD) && !cur.overload_seen) begin
                     state_next.overload_seen = 1'b1;
                  end
                  state_next.phase = dhcptlv_pkg::PH_LEN;
               end
            end
            dhcptlv_pkg::PH_LEN: begin
               state_next.bytes_left = data_byte;
               if (data_byte != 8'd0) begin
                  state_next.phase = dhcptlv_pkg::PH_VALUE;
               end else begin
                  state_next.phase         = dhcptlv_pkg::PH_CODE;
                  state_next.grab_overload = 1'b0;
               end
               done = last;
            end
            dhcptlv_pkg::PH_VALUE: begin
               if (cur.grab_overload) begin
                  state_next.overload_bits = data_byte[1:0];
                  state_next.grab_overload = 1'b0;
               end
               if (cur.collecting) begin
                  emit = 1'b1;
                  if (cur.length_sum != dhcptlv_pkg::LEN_MAX) begin
                     state_next.length_sum = cur.length_sum + dhcptlv_pkg::LEN_W'(1);
                  end
               end
               state_next.bytes_left = left_dec;
               if (left_dec == 8'd0) begin
                  state_next.phase = dhcptlv_pkg::PH_CODE;
               end
               done = last;
            end
            default: begin
               state_next.phase = dhcptlv_pkg::PH_CODE;
            end
         endcase

         if (done) begin
            state_next.finished = 1'b1;
         end else if (!switched) begin
            state_next.position = cur.position + dhcptlv_pkg::POS_W'(1);
         end
      end

      result.valid        = emit || done;
      result.value_byte   = emit ? data_byte : 8'd0;
      result.value_valid  = emit;
      result.scan_done    = done;
      result.found        = state_next.match_seen;
      result.total_length = state_next.length_sum;
   end

endmodule

`default_nettype wire

// ===== hdl/dhcptlv_step_wrap_note.sv =====
`default_nettype none

// Result holding register: keeps one finished result until the receiver
// takes it, and frees itself in the same cycle that it is taken.
module dhcptlv_out_reg (
   input  wire                                clock,
   input  wire                                reset,
   input  wire logic                          load,
   input  wire dhcptlv_pkg::scan_result_type  result,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tvalid,
   output logic [23:0]                        rsp_tdata,
   output logic [0:0]                         rsp_tuser,
   output logic                               rsp_tlast,
   output logic                               space
);

   logic                         valid_ff;
   logic                         valid_in;
   logic [7:0]                   value_ff;
   logic                         vvalid_ff;
   logic                         done_ff;
   logic                         found_ff;
   logic [dhcptlv_pkg::LEN_W-1:0] total_ff;

   assign space = !valid_ff || rsp_tready;

   always_comb begin
      if (load && result.valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         value_ff  <= result.value_byte;
         vvalid_ff <= result.value_valid;
         done_ff   <= result.scan_done;
         found_ff  <= result.found;
         total_ff  <= result.total_length;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, total_ff, found_ff, value_ff};
   assign rsp_tuser  = vvalid_ff;
   assign rsp_tlast  = done_ff;

endmodule

`default_nettype wire
